/* design/ifmt_pkg.sv */
// Shared types, constants and helper functions for the integer to ASCII formatter.
// Used by every module of the formatter; it depends on nothing else.
package ifmt_pkg;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int BCD_DIGITS     = 20;
   localparam int BCD_BITS       = 4 * BCD_DIGITS;
   localparam int WORK_BITS      = 66;
   localparam int DABBLE_STEPS   = 64;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   typedef enum logic [1:0] {
      OP_UDEC = 2'd0,
      OP_SDEC = 2'd1,
      OP_HEX  = 2'd2,
      OP_OCT  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      WSEL_8  = 2'd0,
      WSEL_16 = 2'd1,
      WSEL_32 = 2'd2,
      WSEL_64 = 2'd3
   } width_select_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DABBLE,
      FE_EMIT
   } front_state_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } char_type;

   typedef struct packed {
      logic     valid;
      char_type data;
   } push_type;

   typedef struct packed {
      logic     empty;
      logic     full;
      char_type head;
   } queue_status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      if (nib < 4'd10) begin
         hex_char = CHAR_ZERO + {4'd0, nib};
      end else begin
         base     = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
         hex_char = base + {4'd0, nib - 4'd10};
      end
   endfunction

endpackage

/* design/ifmt_front.sv */
// Front end of the formatter: takes a command, converts decimal values to BCD and
// pushes the characters of the text into the queue. Depends on ifmt_pkg.
module ifmt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [63:0]               req_value,
   input  logic [1:0]                req_opcode,
   input  logic [1:0]                req_width_select,
   input  logic                      req_upper_case,
   input  ifmt_pkg::queue_status_type q_status,
   output ifmt_pkg::push_type         push
);

   ifmt_pkg::front_state_type state_ff, state_in;
   ifmt_pkg::opcode_type      mode_ff, mode_in;
   logic                      upper_ff, upper_in;
   logic                      sign_ff, sign_in;
   logic                      lead_ff, lead_in;
   logic [4:0]                rem_ff, rem_in;
   logic [5:0]                step_ff, step_in;
   logic [ifmt_pkg::WORK_BITS-1:0] work_ff, work_in;
   logic [ifmt_pkg::BCD_BITS-1:0]  bcd_ff, bcd_in;

   logic                      accept;
   logic                      dabble_done;
   logic                      final_push;
   logic                      skip;
   logic [63:0]               mag;
   logic [ifmt_pkg::BCD_BITS-1:0] bcd_adj;
   logic [3:0]                top_digit;
   ifmt_pkg::opcode_type      req_op;

   assign req_op      = ifmt_pkg::opcode_type'(req_opcode);
   assign accept      = start && (state_ff == ifmt_pkg::FE_IDLE);
   assign busy        = (state_ff != ifmt_pkg::FE_IDLE);
   assign dabble_done = (step_ff == 6'(ifmt_pkg::DABBLE_STEPS - 1));
   assign top_digit   = bcd_ff[ifmt_pkg::BCD_BITS-1 -: 4];
   assign skip        = ((mode_ff == ifmt_pkg::OP_UDEC) || (mode_ff == ifmt_pkg::OP_SDEC))
                        && lead_ff && (top_digit == 4'd0) && (rem_ff != 5'd1);
   assign final_push  = (state_ff == ifmt_pkg::FE_EMIT) && !sign_ff && (rem_ff == 5'd1)
                        && !q_status.full;
   assign mag         = (req_op == ifmt_pkg::OP_SDEC && req_value[63]) ?
                        (~req_value + 64'd1) : req_value;

   // Add three to every BCD digit of five or more before the shift.
   always_comb begin
      for (int d = 0; d < ifmt_pkg::BCD_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? (bcd_ff[4*d +: 4] + 4'd3)
                                                          : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ifmt_pkg::FE_IDLE: begin
            if (accept) begin
               if (req_op == ifmt_pkg::OP_UDEC || req_op == ifmt_pkg::OP_SDEC) begin
                  state_in = ifmt_pkg::FE_DABBLE;
               end else begin
                  state_in = ifmt_pkg::FE_EMIT;
               end
            end
         end
         ifmt_pkg::FE_DABBLE: begin
            if (dabble_done) begin
               state_in = ifmt_pkg::FE_EMIT;
            end
         end
         ifmt_pkg::FE_EMIT: begin
            if (final_push) begin
               state_in = ifmt_pkg::FE_IDLE;
            end
         end
         default: state_in = ifmt_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      upper_in   = upper_ff;
      sign_in    = sign_ff;
      lead_in    = lead_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      bcd_in     = bcd_ff;
      push.valid = 1'b0;
      push.data  = '0;
      unique case (state_ff)
         ifmt_pkg::FE_IDLE: begin
            if (accept) begin
               mode_in  = req_op;
               upper_in = req_upper_case;
               sign_in  = (req_op == ifmt_pkg::OP_SDEC) && req_value[63];
               lead_in  = 1'b1;
               step_in  = 6'd0;
               bcd_in   = '0;
               case (req_op)
                  ifmt_pkg::OP_HEX: begin
                     // Left-align the selected width so its top nibble sits at the top.
                     case (ifmt_pkg::width_select_type'(req_width_select))
                        ifmt_pkg::WSEL_8: begin
                           work_in = {req_value[7:0], 58'd0};
                           rem_in  = 5'd2;
                        end
                        ifmt_pkg::WSEL_16: begin
                           work_in = {req_value[15:0], 50'd0};
                           rem_in  = 5'd4;
                        end
                        ifmt_pkg::WSEL_32: begin
                           work_in = {req_value[31:0], 34'd0};
                           rem_in  = 5'd8;
                        end
                        default: begin
                           work_in = {req_value, 2'd0};
                           rem_in  = 5'd16;
                        end
                     endcase
                  end
                  ifmt_pkg::OP_OCT: begin
                     // The first digit may reach one or two bits above the width.
                     case (ifmt_pkg::width_select_type'(req_width_select))
                        ifmt_pkg::WSEL_8: begin
                           work_in = {req_value[8:0], 57'd0};
                           rem_in  = 5'd3;
                        end
                        ifmt_pkg::WSEL_16: begin
                           work_in = {req_value[17:0], 48'd0};
                           rem_in  = 5'd6;
                        end
                        ifmt_pkg::WSEL_32: begin
                           work_in = {req_value[32:0], 33'd0};
                           rem_in  = 5'd11;
                        end
                        default: begin
                           work_in = {2'd0, req_value};
                           rem_in  = 5'd22;
                        end
                     endcase
                  end
                  default: begin
                     work_in = {mag, 2'd0};
                     rem_in  = 5'(ifmt_pkg::BCD_DIGITS);
                  end
               endcase
            end
         end
         ifmt_pkg::FE_DABBLE: begin
            bcd_in  = {bcd_adj[ifmt_pkg::BCD_BITS-2:0], work_ff[ifmt_pkg::WORK_BITS-1]};
            work_in = {work_ff[ifmt_pkg::WORK_BITS-2:0], 1'b0};
            step_in = step_ff + 6'd1;
         end
         ifmt_pkg::FE_EMIT: begin
            if (sign_ff) begin
               push.valid          = 1'b1;
               push.data.character = ifmt_pkg::CHAR_MINUS;
               push.data.last      = 1'b0;
               if (!q_status.full) begin
                  sign_in = 1'b0;
               end
            end else if (skip) begin
               bcd_in = {bcd_ff[ifmt_pkg::BCD_BITS-5:0], 4'd0};
               rem_in = rem_ff - 5'd1;
            end else begin
               push.valid     = 1'b1;
               push.data.last = (rem_ff == 5'd1);
               case (mode_ff)
                  ifmt_pkg::OP_HEX: begin
                     push.data.character =
                        ifmt_pkg::hex_char(work_ff[ifmt_pkg::WORK_BITS-1 -: 4], upper_ff);
                  end
                  ifmt_pkg::OP_OCT: begin
                     push.data.character =
                        ifmt_pkg::CHAR_ZERO + {5'd0, work_ff[ifmt_pkg::WORK_BITS-1 -: 3]};
                  end
                  default: begin
                     push.data.character = ifmt_pkg::CHAR_ZERO + {4'd0, top_digit};
                  end
               endcase
               if (!q_status.full) begin
                  rem_in  = rem_ff - 5'd1;
                  lead_in = 1'b0;
                  bcd_in  = {bcd_ff[ifmt_pkg::BCD_BITS-5:0], 4'd0};
                  if (mode_ff == ifmt_pkg::OP_HEX) begin
                     work_in = {work_ff[ifmt_pkg::WORK_BITS-5:0], 4'd0};
                  end else begin
                     work_in = {work_ff[ifmt_pkg::WORK_BITS-4:0], 3'd0};
                  end
               end
            end
         end
         default: begin
            push.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifmt_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      upper_ff <= upper_in;
      sign_ff  <= sign_in;
      lead_ff  <= lead_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      work_ff  <= work_in;
      bcd_ff   <= bcd_in;
   end

endmodule

/* design/ifmt_queue.sv */
// Character queue between the front end and the output stage of the formatter.
// A small register FIFO; depends on ifmt_pkg.
module ifmt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  ifmt_pkg::push_type          push,
   input  logic                       pop,
   output ifmt_pkg::queue_status_type  status
);

   ifmt_pkg::char_type entry_ff [ifmt_pkg::QUEUE_DEPTH];
   logic [ifmt_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ifmt_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ifmt_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                                do_write;
   logic                                do_read;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (ifmt_pkg::QUEUE_PTR_BITS+1)'(ifmt_pkg::QUEUE_DEPTH));
   assign status.head  = entry_ff[rd_ptr_ff];
   assign do_write     = push.valid && !status.full;
   assign do_read      = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_write ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_read ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (ifmt_pkg::QUEUE_PTR_BITS+1)'(ifmt_pkg::QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_ptr_count_agree: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[ifmt_pkg::QUEUE_PTR_BITS-1:0])
      else $error("queue pointers disagree with occupancy");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      (do_write && !do_read) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue write without read did not grow occupancy");

   a_read_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_read && !do_write) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue read without write did not shrink occupancy");

endmodule

/* design/ifmt_back.sv */
// Output stage of the formatter: drains the character queue one transfer per cycle
// into the registered result ports. Depends on ifmt_pkg.
module ifmt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ifmt_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_character,
   output logic                       rsp_last
);

   logic       strobe_ff, strobe_in;
   logic [7:0] character_ff, character_in;
   logic       last_ff, last_in;

   assign pop = !q_status.empty;

   always_comb begin
      strobe_in    = !q_status.empty;
      character_in = q_status.empty ? character_ff : q_status.head.character;
      last_in      = q_status.empty ? last_ff : q_status.head.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      character_ff <= character_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = character_ff;
   assign rsp_last      = last_ff;

endmodule

/* design/integer_to_ascii_formatter_unit.sv */
// Integer to ASCII formatter: one character transfer per cycle while any are queued,
// most significant first. Decimal values pass through 64 shift-add-3 steps to BCD,
// then leading zeros are skipped; hex and octal digits come from the left-aligned value.
// A four-entry queue lets the front end take the next command as the output stage drains.
// Synchronous active-high reset empties the queue and returns the front end to idle.
module integer_to_ascii_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_width_select,
   input  logic        req_upper_case,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   ifmt_pkg::push_type         push;
   ifmt_pkg::queue_status_type q_status;
   logic                       pop;

   ifmt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_opcode       (req_opcode),
      .req_width_select (req_width_select),
      .req_upper_case   (req_upper_case),
      .q_status         (q_status),
      .push             (push)
   );

   ifmt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (q_status)
   );

   ifmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

/* bench/integer_to_ascii_formatter_unit_tb.sv */
// Self-checking bench for the integer to ASCII formatter: directed and random commands.
// Predicts every character in a small scoreboard class; depends on ifmt_pkg and the unit.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_tb;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 85;
   localparam int DRAIN_CYCLES  = 120;
   localparam int REPORT_LIMIT  = 10;

   class char_scoreboard;
      ifmt_pkg::char_type pending_chars[$];
      int unsigned        failures;
      int unsigned        reported;

      // Works out the full text of one accepted command and queues it, character by character.
      function void note_command(logic [63:0] value, ifmt_pkg::opcode_type op,
                                 ifmt_pkg::width_select_type wsel, logic upper);
         logic [7:0] text[$];
         logic [7:0] digits[20];
         logic [63:0] mag;
         logic [3:0] nib;
         logic [2:0] dig;
         ifmt_pkg::char_type entry;
         int n;
         int nbits;
         int sh;
         nbits = 8 << int'(wsel);
         n = 0;
         case (op)
            ifmt_pkg::OP_UDEC, ifmt_pkg::OP_SDEC: begin
               mag = value;
               if (op == ifmt_pkg::OP_SDEC && value[63]) begin
                  // The most negative value wraps back to itself, read as unsigned 2^63.
                  mag = ~value + 64'd1;
                  text.push_back(ifmt_pkg::CHAR_MINUS);
               end
               if (mag == 64'd0) begin
                  digits[0] = ifmt_pkg::CHAR_ZERO;
                  n = 1;
               end else begin
                  while (mag != 64'd0) begin
                     digits[n] = ifmt_pkg::CHAR_ZERO + 8'(mag % 64'd10);
                     mag = mag / 64'd10;
                     n++;
                  end
               end
               for (int i = n - 1; i >= 0; i--) text.push_back(digits[i]);
            end
            ifmt_pkg::OP_HEX: begin
               for (sh = nbits - 4; sh >= 0; sh -= 4) begin
                  nib = 4'(value >> sh);
                  if (nib < 4'd10) text.push_back(ifmt_pkg::CHAR_ZERO + {4'd0, nib});
                  else text.push_back((upper ? ifmt_pkg::CHAR_UPPER_A : ifmt_pkg::CHAR_LOWER_A)
                                      + {4'd0, nib} - 8'd10);
               end
            end
            default: begin
               for (sh = nbits - nbits % 3; sh >= 0; sh -= 3) begin
                  dig = 3'(value >> sh);
                  text.push_back(ifmt_pkg::CHAR_ZERO + {5'd0, dig});
               end
            end
         endcase
         foreach (text[i]) begin
            entry.character = text[i];
            entry.last      = (i == text.size() - 1);
            pending_chars.push_back(entry);
         end
      endfunction

      function void check_char(logic [7:0] character, logic last);
         ifmt_pkg::char_type want;
         if (pending_chars.size() == 0) begin
            failures++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("unexpected character transfer: char=%h last=%b", character, last);
            end
         end else begin
            want = pending_chars.pop_front();
            if (character !== want.character || last !== want.last) begin
               failures++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("mismatch: expected char=%h last=%b, got char=%h last=%b",
                           want.character, want.last, character, last);
               end
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_value;
   logic [1:0]  req_opcode;
   logic [1:0]  req_width_select;
   logic        req_upper_case;
   logic        rsp_strobe;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   char_scoreboard board;
   bit             quiet_stretch;
   int unsigned    cycle_count;

   integer_to_ascii_formatter_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_opcode       (req_opcode),
      .req_width_select (req_width_select),
      .req_upper_case   (req_upper_case),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Results cannot be held off, so every strobe seen at an edge is a completed transfer.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_char(rsp_character, rsp_last);
   end

   // Drives one command and returns once it has been taken; start is left high so that a
   // following command can go out back to back.
   task automatic send_command(logic [63:0] value, ifmt_pkg::opcode_type op,
                               ifmt_pkg::width_select_type wsel, logic upper);
      int gap;
      if (!quiet_stretch && $urandom_range(0, 99) < 32) begin
         gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 100 : 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_value        <= value;
      req_opcode       <= op;
      req_width_select <= wsel;
      req_upper_case   <= upper;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_command(value, op, wsel, upper);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (board.pending_chars.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] value;
      logic [63:0] full;
      board = new();
      start            <= 1'b0;
      reset            <= 1'b1;
      req_value        <= '0;
      req_opcode       <= ifmt_pkg::OP_UDEC;
      req_width_select <= ifmt_pkg::WSEL_8;
      req_upper_case   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, every mode and width, and the corner cases.
      send_command(64'd0, ifmt_pkg::OP_UDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_UDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'd0, ifmt_pkg::OP_SDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_SDEC, ifmt_pkg::WSEL_64, 1'b1);
      send_command(64'h8000_0000_0000_0000, ifmt_pkg::OP_SDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'h7FFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_SDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'h8000_0000_0000_0000, ifmt_pkg::OP_UDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'd1, ifmt_pkg::OP_SDEC, ifmt_pkg::WSEL_16, 1'b0);
      send_command(64'd9, ifmt_pkg::OP_UDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'd10, ifmt_pkg::OP_UDEC, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'd12345, ifmt_pkg::OP_UDEC, ifmt_pkg::WSEL_64, 1'b1);
      send_command(-64'sd12345, ifmt_pkg::OP_SDEC, ifmt_pkg::WSEL_16, 1'b1);
      send_command(64'h0123_4567_89AB_CDEF, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_64, 1'b0);
      send_command(64'h0123_4567_89AB_CDEF, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_64, 1'b1);
      send_command(64'hFEDC_BA98_7654_3210, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_8, 1'b1);
      send_command(64'hFEDC_BA98_7654_3210, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_16, 1'b0);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_32, 1'b1);
      send_command(64'd0, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'hABCD_EF12_3456_7890, ifmt_pkg::OP_HEX, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_OCT, ifmt_pkg::WSEL_8, 1'b0);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_OCT, ifmt_pkg::WSEL_16, 1'b1);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_OCT, ifmt_pkg::WSEL_32, 1'b0);
      send_command(64'hFFFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_OCT, ifmt_pkg::WSEL_64, 1'b0);
      send_command(64'h7FFF_FFFF_FFFF_FFFF, ifmt_pkg::OP_OCT, ifmt_pkg::WSEL_64, 1'b1);
      send_command(64'd0, ifmt_pkg::OP_OCT, ifmt_pkg::WSEL_64, 1'b0);

      // Hold the sender back until the unit has emptied completely.
      wait_for_drain();

      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         quiet_stretch = (item >= 40 && item < 70);
         if (item == 80) wait_for_drain();
         full = {$urandom, $urandom};
         case ($urandom_range(0, 4))
            0:       value = full;
            1:       value = 64'($urandom_range(0, 1000));
            2:       value = full >> $urandom_range(0, 63);
            3:       value = ~(full >> $urandom_range(0, 63));
            default: begin
               case ($urandom_range(0, 3))
                  0:       value = 64'd0;
                  1:       value = 64'hFFFF_FFFF_FFFF_FFFF;
                  2:       value = 64'h8000_0000_0000_0000;
                  default: value = 64'h7FFF_FFFF_FFFF_FFFF;
               endcase
            end
         endcase
         send_command(value, ifmt_pkg::opcode_type'($urandom_range(0, 3)),
                      ifmt_pkg::width_select_type'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending_chars.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ifmt_pkg.sv
design/ifmt_front.sv
design/ifmt_queue.sv
design/ifmt_back.sv
design/integer_to_ascii_formatter_unit.sv
bench/integer_to_ascii_formatter_unit_tb.sv
